FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/chm_pkg.sv
`timescale 1ns / 1ps

package chm_pkg;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 31;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 32;
  localparam int DIGIT_W     = 8;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_DELETE = 2'd2;

endpackage

FILE: rtl/chm_ram.sv
`timescale 1ns / 1ps

module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/chm_keymod.sv
`timescale 1ns / 1ps

module chm_keymod #(
  parameter int BUCKETS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [chm_pkg::KEY_W-1:0]  key,
  output logic                       busy,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int BW     = $clog2(BUCKETS);
  localparam int RW     = BW + 1;
  localparam int STEPS  = chm_pkg::KEY_W / chm_pkg::DIGIT_W;
  localparam int CNT_W  = $clog2(STEPS);

  logic [chm_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [BW-1:0]             rem_r, rem_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [RW-1:0]             acc;

  // Horner reduction of the key, one byte per cycle, most significant first.
  always_comb begin
    acc = RW'(rem_r);
    for (int i = 0; i < chm_pkg::DIGIT_W; i++) begin
      acc = {acc[BW-1:0], key_r[chm_pkg::KEY_W-1-i]};
      if (acc >= RW'(BUCKETS)) begin
        acc = acc - RW'(BUCKETS);
      end
    end
  end

  always_comb begin
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      key_nxt  = key;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      key_nxt = key_r << chm_pkg::DIGIT_W;
      rem_nxt = acc[BW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    key_r <= key_nxt;
    rem_r <= rem_nxt;
  end

  assign busy   = busy_r;
  assign bucket = rem_r;

endmodule

FILE: rtl/chained_hash_map_bitmap_slots_unit.sv
// Sequence: an insert runs key reduction and the free-map scan side by side, then reads the
//   chain head, writes the new entry at the head of the chain and loads the result; lookup and
//   delete read the chain head and then visit the chain entries in turn until a match or the end.
// Throughput: one request at a time; in_tready is high only while the unit is idle, so a
//   new request is taken at the earliest in the cycle after the previous result is loaded.
// Reset: a clearing pass sets every chain head to empty, with in_tready low.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module chained_hash_map_bitmap_slots_unit #(
  parameter int SLOTS   = 128,
  parameter int BUCKETS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [chm_pkg::IN_TDATA_W-1:0]    in_tdata,   // key [63:0], value [94:64]
  input  logic [chm_pkg::OP_W-1:0]          in_tuser,   // op [1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [chm_pkg::OUT_TDATA_W-1:0]   out_tdata,  // found_value [30:0]
  output logic                              out_tuser   // status [0]
);

  localparam int SW   = $clog2(SLOTS);
  localparam int LW   = $clog2(SLOTS + 1);
  localparam int BW   = $clog2(BUCKETS);
  localparam int CW   = (SLOTS < 32) ? SLOTS : 32;
  localparam int NCH  = (SLOTS + CW - 1) / CW;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PW   = $clog2(CW);
  localparam int MW   = NCH * CW;
  localparam int EW   = LW + chm_pkg::VAL_W + chm_pkg::KEY_W;

  localparam logic [LW-1:0] EMPTY     = LW'(SLOTS);
  localparam logic [MW-1:0] FREE_INIT = MW'({SLOTS{1'b1}});

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_HDAT  = 3'd4;
  localparam logic [2:0] S_WRD   = 3'd5;
  localparam logic [2:0] S_WCHK  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  typedef struct packed {
    logic [LW-1:0]             link;
    logic [chm_pkg::VAL_W-1:0] value;
    logic [chm_pkg::KEY_W-1:0] key;
  } entry_t;

  logic [2:0]                state_r, state_nxt;
  chm_pkg::op_t              op_r, op_nxt;
  logic [chm_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [chm_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [LW-1:0]             cur_r, cur_nxt;
  logic [LW-1:0]             prev_r, prev_nxt;
  logic [chm_pkg::KEY_W-1:0] prev_key_r, prev_key_nxt;
  logic [chm_pkg::VAL_W-1:0] prev_val_r, prev_val_nxt;
  logic [LW-1:0]             steps_r, steps_nxt;
  logic [CHW-1:0]            scan_idx_r, scan_idx_nxt;
  logic                      scan_done_r, scan_done_nxt;
  logic                      slot_hit_r, slot_hit_nxt;
  logic [SW-1:0]             slot_r, slot_nxt;
  logic [MW-1:0]             free_r, free_nxt;
  logic [BW-1:0]             clr_r, clr_nxt;
  logic                      res_status_r, res_status_nxt;
  logic [chm_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_status_r, out_status_nxt;
  logic [chm_pkg::VAL_W-1:0] out_val_r, out_val_nxt;

  logic                      km_start;
  logic                      km_busy;
  logic [BW-1:0]             km_bucket;

  logic                      bkt_we;
  logic [BW-1:0]             bkt_waddr;
  logic [LW-1:0]             bkt_wdata;
  logic [LW-1:0]             head_rd;

  logic                      ent_we;
  logic [SW-1:0]             ent_waddr;
  entry_t                    ent_wdata;
  logic [EW-1:0]             ent_rd_raw;
  entry_t                    ent_rd;

  logic [CW-1:0]             chunk;
  logic                      chunk_hit;
  logic [PW-1:0]             chunk_pos;
  logic                      in_req;

  chm_keymod #(
    .BUCKETS (BUCKETS)
  ) u_keymod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (km_start),
    .key    (key_nxt),
    .busy   (km_busy),
    .bucket (km_bucket)
  );

  chm_ram #(
    .WIDTH (LW),
    .DEPTH (BUCKETS)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (bkt_we),
    .wr_addr (bkt_waddr),
    .wr_data (bkt_wdata),
    .rd_addr (km_bucket),
    .rd_data (head_rd)
  );

  chm_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_addr (cur_r[SW-1:0]),
    .rd_data (ent_rd_raw)
  );

  assign ent_rd = entry_t'(ent_rd_raw);
  assign in_req = in_tvalid && in_tready;

  always_comb begin
    chunk     = free_r[int'(scan_idx_r) * CW +: CW];
    chunk_hit = |chunk;
    chunk_pos = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        chunk_pos = PW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_key_nxt   = prev_key_r;
    prev_val_nxt   = prev_val_r;
    steps_nxt      = steps_r;
    scan_idx_nxt   = scan_idx_r;
    scan_done_nxt  = scan_done_r;
    slot_hit_nxt   = slot_hit_r;
    slot_nxt       = slot_r;
    free_nxt       = free_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    km_start       = 1'b0;
    bkt_we         = 1'b0;
    bkt_waddr      = km_bucket;
    bkt_wdata      = EMPTY;
    ent_we         = 1'b0;
    ent_waddr      = slot_r;
    ent_wdata      = '{link: head_rd, value: val_r, key: key_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_r;
        bkt_wdata = EMPTY;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_tuser;
          key_nxt        = in_tdata[chm_pkg::KEY_W-1:0];
          val_nxt        = in_tdata[chm_pkg::KEY_W +: chm_pkg::VAL_W];
          km_start       = 1'b1;
          scan_idx_nxt   = '0;
          scan_done_nxt  = (in_tuser != chm_pkg::OP_INSERT);
          slot_hit_nxt   = 1'b0;
          res_status_nxt = 1'b1;
          res_val_nxt    = '0;
          state_nxt      = S_HASH;
        end
      end
      S_HASH: begin
        if (!scan_done_r) begin
          if (chunk_hit) begin
            slot_hit_nxt  = 1'b1;
            slot_nxt      = SW'(int'(scan_idx_r) * CW + int'(chunk_pos));
            scan_done_nxt = 1'b1;
          end else if (scan_idx_r == CHW'(NCH - 1)) begin
            scan_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (!km_busy && scan_done_r) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_HDAT;
      end
      S_HDAT: begin
        if (op_r == chm_pkg::OP_INSERT) begin
          if (slot_hit_r) begin
            ent_we           = 1'b1;
            ent_waddr        = slot_r;
            ent_wdata        = '{link: head_rd, value: val_r, key: key_r};
            bkt_we           = 1'b1;
            bkt_wdata        = LW'(slot_r);
            free_nxt[slot_r] = 1'b0;
            res_status_nxt   = 1'b0;
          end
          state_nxt = S_FIN;
        end else if (op_r == chm_pkg::OP_LOOKUP || op_r == chm_pkg::OP_DELETE) begin
          cur_nxt   = head_rd;
          prev_nxt  = EMPTY;
          steps_nxt = '0;
          state_nxt = S_WRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WRD: begin
        if (cur_r >= EMPTY || steps_r >= EMPTY) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (ent_rd.key == key_r) begin
          res_status_nxt = 1'b0;
          if (op_r == chm_pkg::OP_LOOKUP) begin
            res_val_nxt = ent_rd.value;
          end else begin
            if (prev_r < EMPTY) begin
              ent_we    = 1'b1;
              ent_waddr = prev_r[SW-1:0];
              ent_wdata = '{link: ent_rd.link, value: prev_val_r, key: prev_key_r};
            end else begin
              bkt_we    = 1'b1;
              bkt_wdata = ent_rd.link;
            end
            free_nxt[cur_r[SW-1:0]] = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          prev_nxt     = cur_r;
          prev_key_nxt = ent_rd.key;
          prev_val_nxt = ent_rd.value;
          cur_nxt      = ent_rd.link;
          steps_nxt    = steps_r + 1'b1;
          state_nxt    = S_WRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      scan_done_r <= 1'b0;
      free_r      <= FREE_INIT;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      scan_done_r <= scan_done_nxt;
      free_r      <= free_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_key_r   <= prev_key_nxt;
    prev_val_r   <= prev_val_nxt;
    steps_r      <= steps_nxt;
    scan_idx_r   <= scan_idx_nxt;
    slot_hit_r   <= slot_hit_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = chm_pkg::OUT_TDATA_W'(out_val_r);
  assign out_tuser  = out_status_r;

  `ASSERT_NEXT(a_req_starts_hash, clk, rst_n, in_req, (state_r == S_HASH) && km_busy, "request did not start key reduction")
  `ASSERT_NEXT(a_fin_loads_result, clk, rst_n, (state_r == S_FIN) && (!out_valid_r || out_tready), out_valid_r && (state_r == S_IDLE), "finished request was not loaded into the output register")
  `ASSERT_SAME(a_walk_in_range, clk, rst_n, state_r == S_WCHK, cur_r < EMPTY, "chain walk read an entry beyond the slot range")
  `ASSERT_SAME(a_insert_free_slot, clk, rst_n, (state_r == S_HDAT) && ent_we, free_r[slot_r], "insert claimed a slot that was not free")

endmodule
